// ----- sv/voxel_grid_centroid_downsample_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the voxel grid centroid downsampler
// Clocked checks on clk with and without the reset disable.
// ---------------------------------------------------------------------------
`ifndef VOXEL_GRID_CENTROID_DOWNSAMPLE_DEFINES_SVH
`define VOXEL_GRID_CENTROID_DOWNSAMPLE_DEFINES_SVH
`ifndef SYNTHESIS
`define VGCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VGCD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VGCD_ASSERT(label, prop, msg)
`define VGCD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- sv/vgcd_pkg.sv -----
// ---------------------------------------------------------------------------
// vgcd_pkg
// Sizes, slot layout, control groups and codes of the voxel downsampler.
// ---------------------------------------------------------------------------
`default_nettype none
package vgcd_pkg;

  localparam int VOXEL_SLOTS = 64;
  localparam int MAX_POINTS  = 65536;

  localparam int SLOT_CNT_W = $clog2(VOXEL_SLOTS + 1);
  localparam int PT_W       = $clog2(MAX_POINTS + 1);

  localparam int POS_W  = 32;
  localparam int NRM_W  = 16;
  localparam int KEY_W  = 32;
  localparam int CNT_W  = PT_W;
  localparam int SPOS_W = POS_W + PT_W;
  localparam int SNRM_W = NRM_W + PT_W;
  localparam int SCOL_W = 8 + PT_W;
  localparam int SATT_W = 16 + PT_W;

  localparam int DATA_W = 200;
  localparam int DVD_W  = 64;
  localparam int DSR_W  = 32;
  localparam int MAG_W  = 31;
  localparam int SH_W   = 6;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_OVF   = 2'd2;

  localparam logic REG_INV_VOXEL_SIZE = 1'b0;
  localparam logic REG_ATTR_ENABLE    = 1'b1;

  localparam int ATTR_NORMAL = 0;
  localparam int ATTR_COLOR  = 1;
  localparam int ATTR_CONF   = 2;
  localparam int ATTR_SCALE  = 3;

  typedef struct packed {
    logic [KEY_W-1:0]  key_x;
    logic [KEY_W-1:0]  key_y;
    logic [KEY_W-1:0]  key_z;
    logic [SPOS_W-1:0] sum_pos_x;
    logic [SPOS_W-1:0] sum_pos_y;
    logic [SPOS_W-1:0] sum_pos_z;
    logic [SNRM_W-1:0] sum_nrm_x;
    logic [SNRM_W-1:0] sum_nrm_y;
    logic [SNRM_W-1:0] sum_nrm_z;
    logic [SCOL_W-1:0] sum_red;
    logic [SCOL_W-1:0] sum_green;
    logic [SCOL_W-1:0] sum_blue;
    logic [SATT_W-1:0] sum_conf;
    logic [SATT_W-1:0] sum_scale;
    logic [CNT_W-1:0]  count;
  } slot_t;

  typedef struct packed {
    logic active;
    logic load;
    logic acc;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic [31:0] avg_x;
    logic [31:0] avg_y;
    logic [31:0] avg_z;
    logic [15:0] avg_nx;
    logic [15:0] avg_ny;
    logic [15:0] avg_nz;
    logic [23:0] avg_rgb;
    logic [15:0] avg_conf;
    logic [15:0] avg_scale;
    logic [1:0]  status;
    logic        run_last;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/voxel_grid_centroid_downsample.sv -----
// ---------------------------------------------------------------------------
// voxel_grid_centroid_downsample
// Bins points into voxels held in a chain of slot cells; on the closing word
// emits one averaged point per voxel in order of first appearance.
//
//   channel   dir  payload                                    end marker
//   s_axis    in   pos x/y/z, normal x/y/z, rgb, conf, scale  tlast = cloud end
//   m_axis    out  centroid, unit normal, rgb, conf, scale    tlast = run last
//   cfg       in   inv_voxel_size, attribute_enable           none
//
// A point word passes through accept, three multiply and key steps and a slot match.
// A closing word then runs, per voxel, the bit-serial divider for eleven 64-step
// divisions (eight when the normal sum is zero) and the 32-step square root.
// Reset clears the counters, state and configuration; slot contents are loaded on first use.
// A stalled result holds in the output register; emission waits on it.
// ---------------------------------------------------------------------------
`default_nettype none
`include "voxel_grid_centroid_downsample_defines.svh"
module voxel_grid_centroid_downsample (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, color_rgb, confidence,
  // point_scale
  input  logic [199:0] s_tdata,
  // no_point
  input  logic [0:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // avg_x, avg_y, avg_z, avg_normal_x, avg_normal_y, avg_normal_z,
  // avg_color_rgb, avg_confidence, avg_scale
  output logic [199:0] m_tdata,
  // status
  output logic [1:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_wen,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import vgcd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_KEY   = 6'b000100,
    S_MATCH = 6'b001000,
    S_EMIT  = 6'b010000,
    S_WAIT  = 6'b100000
  } st_t;

  st_t st;
  logic [31:0] voxel_scale;
  logic [3:0]  attr;
  logic [DATA_W-1:0] in_data;
  logic        in_end;
  logic [1:0]  axis;
  logic [63:0] prod;
  logic        neg;
  logic [31:0] kx, ky, kz;
  logic [SLOT_CNT_W-1:0] slots_used;
  logic [PT_W-1:0]       points_taken;
  logic                  overflow;

  logic [31:0] psel, pmag, key_new;
  logic [64:0] tprod;
  slot_t       pt;
  slot_t       slot_arr [VOXEL_SLOTS];
  cell_ctl_t   ctl [VOXEL_SLOTS];
  logic [VOXEL_SLOTS-1:0] hit;
  logic        any_hit, full_pts, do_acc, do_load, emit_busy, take;
  result_t     res;

  assign s_tready = st == S_IDLE;

  always_comb begin
    unique case (axis)
      2'd0: psel = in_data[31:0];
      2'd1: psel = in_data[63:32];
      2'd2: psel = in_data[95:64];
      default: psel = '0;
    endcase
    pmag    = psel[31] ? 32'(0) - psel : psel;
    tprod   = {1'b0, prod} + 65'h0_FFFF_FFFF;
    key_new = neg ? 32'(0) - tprod[63:32] : prod[63:32];
  end

  always_comb begin
    pt.key_x     = kx;
    pt.key_y     = ky;
    pt.key_z     = kz;
    pt.sum_pos_x = {{(SPOS_W-32){in_data[31]}}, in_data[31:0]};
    pt.sum_pos_y = {{(SPOS_W-32){in_data[63]}}, in_data[63:32]};
    pt.sum_pos_z = {{(SPOS_W-32){in_data[95]}}, in_data[95:64]};
    pt.sum_nrm_x = {{(SNRM_W-16){in_data[111]}}, in_data[111:96]};
    pt.sum_nrm_y = {{(SNRM_W-16){in_data[127]}}, in_data[127:112]};
    pt.sum_nrm_z = {{(SNRM_W-16){in_data[143]}}, in_data[143:128]};
    pt.sum_red   = SCOL_W'(in_data[167:160]);
    pt.sum_green = SCOL_W'(in_data[159:152]);
    pt.sum_blue  = SCOL_W'(in_data[151:144]);
    pt.sum_conf  = SATT_W'(in_data[183:168]);
    pt.sum_scale = SATT_W'(in_data[199:184]);
    pt.count     = CNT_W'(1);
  end

  assign any_hit  = |hit;
  assign full_pts = points_taken >= PT_W'(MAX_POINTS);
  assign do_acc   = (st == S_MATCH) && !full_pts && any_hit;
  assign do_load  = (st == S_MATCH) && !full_pts && !any_hit
                    && (slots_used < SLOT_CNT_W'(VOXEL_SLOTS));

  for (genvar i = 0; i < VOXEL_SLOTS; i++) begin : g_cell
    assign ctl[i].active = SLOT_CNT_W'(i) < slots_used;
    assign ctl[i].load   = do_load && (SLOT_CNT_W'(i) == slots_used);
    assign ctl[i].acc    = do_acc;
    assign ctl[i].shift  = take;
    if (i == VOXEL_SLOTS - 1) begin : g_tail
      vgcd_cell u_cell (
        .clk(clk), .ctl(ctl[i]), .pt(pt), .nb(slot_arr[i]),
        .slot(slot_arr[i]), .hit(hit[i])
      );
    end else begin : g_body
      vgcd_cell u_cell (
        .clk(clk), .ctl(ctl[i]), .pt(pt), .nb(slot_arr[i+1]),
        .slot(slot_arr[i]), .hit(hit[i])
      );
    end
  end

  vgcd_emit u_emit (
    .clk(clk), .rst(rst), .start(st == S_EMIT), .n_slots(slots_used),
    .ovf(overflow), .attr(attr), .head(slot_arr[0]), .take(take),
    .busy(emit_busy), .res(res), .out_valid(m_tvalid), .out_ready(m_tready)
  );

  assign m_tdata = {res.avg_scale, res.avg_conf, res.avg_rgb, res.avg_nz, res.avg_ny,
                    res.avg_nx, res.avg_z, res.avg_y, res.avg_x};
  assign m_tuser = res.status;
  assign m_tlast = res.run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_scale <= 32'h0001_0000;
      attr        <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_INV_VOXEL_SIZE: voxel_scale <= cfg_data;
        REG_ATTR_ENABLE:    attr <= cfg_data[3:0];
        default:            attr <= attr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      slots_used   <= '0;
      points_taken <= '0;
      overflow     <= 1'b0;
      axis         <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          axis <= '0;
          if (s_tvalid) begin
            priority if (!s_tuser[0]) st <= S_MUL;
            else if (s_tlast) st <= S_EMIT;
            else st <= S_IDLE;
          end
        end
        S_MUL: st <= S_KEY;
        S_KEY: begin
          if (axis == 2'd2) begin
            st <= S_MATCH;
          end else begin
            axis <= axis + 2'd1;
            st   <= S_MUL;
          end
        end
        S_MATCH: begin
          if (do_acc || do_load) points_taken <= points_taken + 1'b1;
          else overflow <= 1'b1;
          if (do_load) slots_used <= slots_used + 1'b1;
          st <= in_end ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          slots_used   <= '0;
          points_taken <= '0;
          overflow     <= 1'b0;
          st           <= S_WAIT;
        end
        S_WAIT: if (!emit_busy) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_end  <= s_tlast;
    end
    if (st == S_MUL) begin
      prod <= pmag * voxel_scale;
      neg  <= psel[31];
    end
    if (st == S_KEY) begin
      unique case (axis)
        2'd0: kx <= key_new;
        2'd1: ky <= key_new;
        default: kz <= key_new;
      endcase
    end
  end

  `VGCD_ASSERT(a_busy_blocks_input, (emit_busy |-> !s_tready), "input taken during emission")
  `VGCD_ASSERT(a_single_hit, ((st == S_MATCH && any_hit) |-> $onehot(hit)), "voxel key in two slots")
  `VGCD_ASSERT_ALWAYS(a_slots_bound, (rst || (slots_used <= SLOT_CNT_W'(VOXEL_SLOTS))), "slot count overrun")
  `VGCD_ASSERT(a_load_free_slot, (do_load |=> (slots_used != '0)), "slot load lost")

endmodule
`default_nettype wire

// ----- sv/vgcd_cell.sv -----
// ---------------------------------------------------------------------------
// vgcd_cell
// One voxel slot: key match, load, accumulate, shift towards the head.
// ---------------------------------------------------------------------------
`default_nettype none
module vgcd_cell (
  input  logic              clk,
  input  vgcd_pkg::cell_ctl_t ctl,
  input  vgcd_pkg::slot_t   pt,
  input  vgcd_pkg::slot_t   nb,
  output vgcd_pkg::slot_t   slot,
  output logic              hit
);
  import vgcd_pkg::*;

  assign hit = ctl.active && (slot.key_x == pt.key_x) && (slot.key_y == pt.key_y)
               && (slot.key_z == pt.key_z);

  always_ff @(posedge clk) begin
    priority if (ctl.shift) begin
      slot <= nb;
    end else if (ctl.load) begin
      slot <= pt;
    end else if (ctl.acc && hit) begin
      slot.sum_pos_x <= slot.sum_pos_x + pt.sum_pos_x;
      slot.sum_pos_y <= slot.sum_pos_y + pt.sum_pos_y;
      slot.sum_pos_z <= slot.sum_pos_z + pt.sum_pos_z;
      slot.sum_nrm_x <= slot.sum_nrm_x + pt.sum_nrm_x;
      slot.sum_nrm_y <= slot.sum_nrm_y + pt.sum_nrm_y;
      slot.sum_nrm_z <= slot.sum_nrm_z + pt.sum_nrm_z;
      slot.sum_red   <= slot.sum_red + pt.sum_red;
      slot.sum_green <= slot.sum_green + pt.sum_green;
      slot.sum_blue  <= slot.sum_blue + pt.sum_blue;
      slot.sum_conf  <= slot.sum_conf + pt.sum_conf;
      slot.sum_scale <= slot.sum_scale + pt.sum_scale;
      slot.count     <= slot.count + pt.count;
    end else begin
      slot <= slot;
    end
  end

endmodule
`default_nettype wire

// ----- sv/vgcd_div.sv -----
// ---------------------------------------------------------------------------
// vgcd_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module vgcd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [vgcd_pkg::DVD_W-1:0]  dividend,
  input  logic [vgcd_pkg::DSR_W-1:0]  divisor,
  output logic [vgcd_pkg::DVD_W-1:0]  quotient,
  output logic                        done
);
  import vgcd_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W:0]   trial;
  logic             ge;

  assign trial = {rem, quotient[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? DSR_W'(trial - {1'b0, dsr}) : trial[DSR_W-1:0];
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- sv/vgcd_emit.sv -----
// ---------------------------------------------------------------------------
// vgcd_emit
// Takes slots off the chain head, averages them and renormalises normals.
// ---------------------------------------------------------------------------
`default_nettype none
module vgcd_emit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [vgcd_pkg::SLOT_CNT_W-1:0] n_slots,
  input  logic                            ovf,
  input  logic [3:0]                      attr,
  input  vgcd_pkg::slot_t                 head,
  output logic                            take,
  output logic                            busy,
  output vgcd_pkg::result_t               res,
  output logic                            out_valid,
  input  logic                            out_ready
);
  import vgcd_pkg::*;

  typedef enum logic [8:0] {
    E_IDLE = 9'b000000001,
    E_LOAD = 9'b000000010,
    E_DSET = 9'b000000100,
    E_DRUN = 9'b000001000,
    E_NRM  = 9'b000010000,
    E_SQ   = 9'b000100000,
    E_ACC  = 9'b001000000,
    E_SQRT = 9'b010000000,
    E_PUSH = 9'b100000000
  } est_t;

  typedef enum logic [3:0] {
    JOB_PX = 4'd0, JOB_PY = 4'd1, JOB_PZ = 4'd2,
    JOB_R  = 4'd3, JOB_G  = 4'd4, JOB_B  = 4'd5,
    JOB_CF = 4'd6, JOB_SC = 4'd7,
    JOB_NX = 4'd8, JOB_NY = 4'd9, JOB_NZ = 4'd10
  } job_t;

  est_t  st;
  job_t  job;
  slot_t cur;
  logic [SLOT_CNT_W-1:0] left;
  logic        ovf_r, empty_r, nrm_zero;
  logic [31:0] qx, qy, qz;
  logic [15:0] qn [3];
  logic [7:0]  qr, qg, qb;
  logic [15:0] qc, qs;
  logic [MAG_W-1:0] m [3];
  logic [1:0]  axis;
  logic [63:0] sq, v, r, bitv;
  logic [2*MAG_W-1:0] prod;
  logic [31:0] len;

  logic [DVD_W-1:0] dvd, quot;
  logic [DSR_W-1:0] dsr;
  logic             div_done;
  logic             push;

  logic [SPOS_W-1:0] mp [3];
  logic              np [3];
  logic [SNRM_W-1:0] sn [3];
  logic [SNRM_W-1:0] an [3];
  logic [SNRM_W-1:0] mx;
  logic [SH_W-1:0]   k;
  logic [MAG_W-1:0]  m_next [3];
  logic [63:0]       t_sq, r_next, v_next;
  logic [CNT_W-1:0]  half;
  result_t           res_next;

  vgcd_div u_div (
    .clk(clk), .rst(rst), .start(st == E_DSET), .dividend(dvd), .divisor(dsr),
    .quotient(quot), .done(div_done)
  );

  assign take = st == E_LOAD;
  assign busy = st != E_IDLE;
  assign push = (st == E_PUSH) && (!out_valid || out_ready);
  assign half = cur.count >> 1;

  always_comb begin
    sn[0] = cur.sum_nrm_x;
    sn[1] = cur.sum_nrm_y;
    sn[2] = cur.sum_nrm_z;
    np[0] = cur.sum_pos_x[SPOS_W-1];
    np[1] = cur.sum_pos_y[SPOS_W-1];
    np[2] = cur.sum_pos_z[SPOS_W-1];
    mp[0] = np[0] ? SPOS_W'(0) - cur.sum_pos_x : cur.sum_pos_x;
    mp[1] = np[1] ? SPOS_W'(0) - cur.sum_pos_y : cur.sum_pos_y;
    mp[2] = np[2] ? SPOS_W'(0) - cur.sum_pos_z : cur.sum_pos_z;
    for (int i = 0; i < 3; i++) begin
      an[i] = sn[i][SNRM_W-1] ? SNRM_W'(0) - sn[i] : sn[i];
    end
    mx = an[0];
    if (an[1] > mx) mx = an[1];
    if (an[2] > mx) mx = an[2];
    k = '0;
    for (int b = 31; b < SNRM_W; b++) begin
      if (mx[b]) k = SH_W'(b - 30);
    end
    for (int i = 0; i < 3; i++) begin
      m_next[i] = MAG_W'(an[i] >> k);
    end
  end

  always_comb begin
    dsr = DSR_W'(cur.count);
    unique case (job)
      JOB_PX: dvd = DVD_W'(mp[0]) + DVD_W'(half);
      JOB_PY: dvd = DVD_W'(mp[1]) + DVD_W'(half);
      JOB_PZ: dvd = DVD_W'(mp[2]) + DVD_W'(half);
      JOB_R:  dvd = DVD_W'(cur.sum_red) + DVD_W'(half);
      JOB_G:  dvd = DVD_W'(cur.sum_green) + DVD_W'(half);
      JOB_B:  dvd = DVD_W'(cur.sum_blue) + DVD_W'(half);
      JOB_CF: dvd = DVD_W'(cur.sum_conf) + DVD_W'(half);
      JOB_SC: dvd = DVD_W'(cur.sum_scale) + DVD_W'(half);
      JOB_NX: begin
        dvd = (DVD_W'(m[0]) << 14) + DVD_W'(len[31:1]);
        dsr = len;
      end
      JOB_NY: begin
        dvd = (DVD_W'(m[1]) << 14) + DVD_W'(len[31:1]);
        dsr = len;
      end
      JOB_NZ: begin
        dvd = (DVD_W'(m[2]) << 14) + DVD_W'(len[31:1]);
        dsr = len;
      end
      default: dvd = '0;
    endcase
  end

  always_comb begin
    t_sq = r + bitv;
    if (v >= t_sq) begin
      v_next = v - t_sq;
      r_next = (r >> 1) + bitv;
    end else begin
      v_next = v;
      r_next = r >> 1;
    end
  end

  always_comb begin
    res_next = '0;
    res_next.run_last = left == '0;
    if (empty_r) begin
      res_next.status = STATUS_EMPTY;
    end else begin
      res_next.status = ovf_r ? STATUS_OVF : STATUS_OK;
      res_next.avg_x  = qx;
      res_next.avg_y  = qy;
      res_next.avg_z  = qz;
      if (attr[ATTR_NORMAL] && !nrm_zero) begin
        res_next.avg_nx = qn[0];
        res_next.avg_ny = qn[1];
        res_next.avg_nz = qn[2];
      end
      if (attr[ATTR_COLOR]) res_next.avg_rgb = {qr, qg, qb};
      if (attr[ATTR_CONF])  res_next.avg_conf = qc;
      if (attr[ATTR_SCALE]) res_next.avg_scale = qs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (push) out_valid <= 1'b1;
      unique case (st)
        E_IDLE: if (start) st <= (n_slots == '0) ? E_PUSH : E_LOAD;
        E_LOAD: st <= E_DSET;
        E_DSET: st <= E_DRUN;
        E_DRUN: begin
          if (div_done) begin
            priority if (job == JOB_SC) st <= E_NRM;
            else if (job == JOB_NZ) st <= E_PUSH;
            else st <= E_DSET;
          end
        end
        E_NRM:  st <= E_SQ;
        E_SQ:   st <= E_ACC;
        E_ACC:  st <= (axis == 2'd2) ? E_SQRT : E_SQ;
        E_SQRT: if (bitv[0]) st <= nrm_zero ? E_PUSH : E_DSET;
        E_PUSH: if (push) st <= (left == '0) ? E_IDLE : E_LOAD;
        default: st <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) res <= res_next;
    unique case (st)
      E_IDLE: begin
        left    <= n_slots;
        ovf_r   <= ovf;
        empty_r <= n_slots == '0;
      end
      E_LOAD: begin
        cur  <= head;
        left <= left - 1'b1;
        job  <= JOB_PX;
      end
      E_DRUN: begin
        if (div_done) begin
          job <= job_t'(job + 4'd1);
          unique case (job)
            JOB_PX: qx <= np[0] ? 32'(0) - quot[31:0] : quot[31:0];
            JOB_PY: qy <= np[1] ? 32'(0) - quot[31:0] : quot[31:0];
            JOB_PZ: qz <= np[2] ? 32'(0) - quot[31:0] : quot[31:0];
            JOB_R:  qr <= quot[7:0];
            JOB_G:  qg <= quot[7:0];
            JOB_B:  qb <= quot[7:0];
            JOB_CF: qc <= quot[15:0];
            JOB_SC: qs <= quot[15:0];
            JOB_NX: qn[0] <= sn[0][SNRM_W-1] ? 16'(0) - quot[15:0] : quot[15:0];
            JOB_NY: qn[1] <= sn[1][SNRM_W-1] ? 16'(0) - quot[15:0] : quot[15:0];
            JOB_NZ: qn[2] <= sn[2][SNRM_W-1] ? 16'(0) - quot[15:0] : quot[15:0];
            default: qs <= qs;
          endcase
        end
      end
      E_NRM: begin
        m        <= m_next;
        nrm_zero <= mx == '0;
        axis     <= 2'd0;
        sq       <= '0;
      end
      E_SQ: begin
        unique case (axis)
          2'd0: prod <= m[0] * m[0];
          2'd1: prod <= m[1] * m[1];
          default: prod <= m[2] * m[2];
        endcase
      end
      E_ACC: begin
        if (axis == 2'd2) begin
          v    <= sq + 64'(prod);
          r    <= '0;
          bitv <= 64'(1) << 62;
        end else begin
          sq   <= sq + 64'(prod);
          axis <= axis + 2'd1;
        end
      end
      E_SQRT: begin
        v    <= v_next;
        r    <= r_next;
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          len <= r_next[31:0];
          job <= JOB_NX;
        end
      end
      default: len <= len;
    endcase
  end

endmodule
`default_nettype wire
